>>> sv/assert_macros.svh
// Shared assertion macros for the scheduler RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/tsms_pkg.sv
package tsms_pkg;

    localparam int PORTS       = 4;
    localparam int QUEUE_DEPTH = 16;
    localparam int POS_BITS    = 11;

    localparam int PORT_W    = 2;
    localparam int PCT_W     = 7;
    localparam int TIME_W    = 32;
    localparam int KIND_W    = 2;
    localparam int CNT_W     = 30;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_W     = 11;

    localparam int SLOT_W = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);
    localparam int ADDR_W = $clog2(PORTS * QUEUE_DEPTH);

    // percent-to-target arithmetic: floor(num / 100) by reciprocal plus one fix-up
    localparam int NUM_W       = POS_BITS + 9;
    localparam int MAG_W       = NUM_W - 1;
    localparam int RECIP_SHIFT = 26;
    localparam int RECIP_W     = 20;
    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'((64'd1 << RECIP_SHIFT) / 64'd100);
    localparam int MULK_W      = MAG_W + RECIP_W;

    // interpolation: elapsed * |diff| divided by the duration
    localparam int PROD_W = TIME_W + POS_BITS;
    localparam int DIVC_W = $clog2(PROD_W + 1);

    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    localparam logic [KIND_W-1:0] KIND_ACCEPT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_POSITION = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FULL     = 2'd2;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    typedef enum logic [1:0] {
        OSEL_ACCEPT,
        OSEL_FULL,
        OSEL_PEND,
        OSEL_INTERP
    } osel_t;

    typedef struct packed {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   dur;
        logic [POS_BITS-1:0] target;
        logic [POS_BITS-1:0] origin;
        logic                captured;
    } entry_t;

    typedef struct packed {
        logic  capture;
        logic  ins_init;
        logic  rd_ins;
        logic  rd_head;
        logic  ins_shift;
        logic  ins_place;
        logic  drop;
        logic  cap_wb;
        logic  mul_go;
        logic  div_start;
        logic  load_out;
        osel_t osel;
        logic  out_last;
        logic  pend_clr;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic port_ok;
        logic full;
        logic k_zero;
        logic later;
        logic fill_zero;
        logic not_started;
        logic finished;
        logic div_done;
        logic out_free;
        logic pend_vld;
    } sts_t;

endpackage

>>> sv/timed_servo_move_scheduler.sv
// Timed servo move scheduler.
// Request channel: in_valid / in_stall carry op, port and the move fields.
// op 0 enqueues a move into the port's start-ordered queue and answers with
// one result (kind 0 with move_id, or kind 2 when the queue is full).
// op 1 is an update tick: emit the final position of each finished head and
// drop it, then an interpolated position for a running head; last marks the
// final result. A tick that finds nothing started answers with no result.
// Result channel: out_valid / out_stall, one output register.
// An enqueue steps over each queued move that starts later before it loads
// its result; the sorted insert walks the queue through the single memory read
// port. A full queue answers from decode without a walk. A tick drops each
// finished head in turn, then evaluates a running head, whose position comes
// from the one bit per cycle divider over 43 quotient bits. One request is in
// work at a time; in_stall is high until it is done, so the next request is
// taken in the cycle after the last result is loaded, and while the receiver
// stalls the scheduler holds its result and waits. Reset clears the queues,
// the id counter and the output register and sets each port's range to
// 0..2047; queue entries hold no reset value. Configuration (cfg_we, cfg_index,
// cfg_data) must be written only while idle; the block does not enforce this.
module timed_servo_move_scheduler (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic                             op,
    input  logic [tsms_pkg::PORT_W-1:0]      port,
    input  logic [tsms_pkg::PCT_W-1:0]       percent,
    input  logic [tsms_pkg::TIME_W-1:0]      length_ms,
    input  logic [tsms_pkg::TIME_W-1:0]      wait_ms,
    input  logic [tsms_pkg::TIME_W-1:0]      now_ms,
    input  logic [tsms_pkg::POS_BITS-1:0]    current_position,
    input  logic                             cfg_we,
    input  logic [tsms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsms_pkg::CFG_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tsms_pkg::KIND_W-1:0]      kind,
    output logic [tsms_pkg::TIME_W-1:0]      move_id,
    output logic [tsms_pkg::PORT_W-1:0]      out_port,
    output logic [tsms_pkg::POS_BITS-1:0]    position,
    output logic                             last
);

    // command and status between sequencer and datapath
    tsms_pkg::cmd_t cmd;
    tsms_pkg::sts_t sts;

    // sequencer: decode, insert walk, head walk, divide wait
    tsms_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    // datapath: queues in one memory, target math, divider, output register
    tsms_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .op               (op),
        .port             (port),
        .percent          (percent),
        .length_ms        (length_ms),
        .wait_ms          (wait_ms),
        .now_ms           (now_ms),
        .current_position (current_position),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .kind             (kind),
        .move_id          (move_id),
        .out_port         (out_port),
        .position         (position),
        .last             (last),
        .cmd              (cmd),
        .sts              (sts)
    );

endmodule

>>> sv/tsms_ctrl.sv
module tsms_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_stall,
    input  tsms_pkg::sts_t   sts,
    output tsms_pkg::cmd_t   cmd
);

    typedef enum logic [13:0] {
        ST_IDLE      = 14'b00000000000001,
        ST_DECODE    = 14'b00000000000010,
        ST_FULL_OUT  = 14'b00000000000100,
        ST_ENQ_T1    = 14'b00000000001000,
        ST_ENQ_T2    = 14'b00000000010000,
        ST_ENQ_T3    = 14'b00000000100000,
        ST_INS_CHK   = 14'b00000001000000,
        ST_INS_CMP   = 14'b00000010000000,
        ST_INS_PLACE = 14'b00000100000000,
        ST_TCK_CHK   = 14'b00001000000000,
        ST_TCK_EVAL  = 14'b00010000000000,
        ST_TCK_DVS   = 14'b00100000000000,
        ST_TCK_DIV   = 14'b01000000000000,
        ST_TCK_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_stall = (state_reg != ST_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.osel   = tsms_pkg::OSEL_ACCEPT;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE:
            begin
                cmd.ins_init = 1'b1;
                if (sts.is_tick)
                begin
                    state_next = sts.port_ok ? ST_TCK_CHK : ST_IDLE;
                end
                else if (!sts.port_ok || sts.full)
                begin
                    state_next = ST_FULL_OUT;
                end
                else
                begin
                    state_next = ST_ENQ_T1;
                end
            end
            ST_FULL_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.osel     = tsms_pkg::OSEL_FULL;
                    state_next   = ST_IDLE;
                end
            end
            ST_ENQ_T1:
            begin
                state_next = ST_ENQ_T2;
            end
            ST_ENQ_T2:
            begin
                state_next = ST_ENQ_T3;
            end
            ST_ENQ_T3:
            begin
                state_next = ST_INS_CHK;
            end
            ST_INS_CHK:
            begin
                if (sts.k_zero)
                begin
                    state_next = ST_INS_PLACE;
                end
                else
                begin
                    cmd.rd_ins = 1'b1;
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                if (sts.later)
                begin
                    cmd.ins_shift = 1'b1;
                    state_next    = ST_INS_CHK;
                end
                else
                begin
                    state_next = ST_INS_PLACE;
                end
            end
            ST_INS_PLACE:
            begin
                if (sts.out_free)
                begin
                    cmd.ins_place = 1'b1;
                    cmd.load_out  = 1'b1;
                    cmd.osel      = tsms_pkg::OSEL_ACCEPT;
                    state_next    = ST_IDLE;
                end
            end
            ST_TCK_CHK:
            begin
                if (!sts.fill_zero)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = ST_TCK_EVAL;
                end
                else if (!sts.pend_vld)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.osel     = tsms_pkg::OSEL_PEND;
                    cmd.out_last = 1'b1;
                    cmd.pend_clr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_TCK_EVAL:
            begin
                if (sts.pend_vld)
                begin
                    if (sts.out_free)
                    begin
                        cmd.load_out = 1'b1;
                        cmd.osel     = tsms_pkg::OSEL_PEND;
                        cmd.out_last = sts.not_started;
                        cmd.pend_clr = 1'b1;
                        if (sts.not_started)
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                end
                else if (sts.not_started)
                begin
                    state_next = ST_IDLE;
                end
                else if (sts.finished)
                begin
                    cmd.drop   = 1'b1;
                    state_next = ST_TCK_CHK;
                end
                else
                begin
                    cmd.cap_wb = 1'b1;
                    cmd.mul_go = 1'b1;
                    state_next = ST_TCK_DVS;
                end
            end
            ST_TCK_DVS:
            begin
                cmd.div_start = 1'b1;
                state_next    = ST_TCK_DIV;
            end
            ST_TCK_DIV:
            begin
                if (sts.div_done)
                begin
                    state_next = ST_TCK_OUT;
                end
            end
            ST_TCK_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    cmd.osel     = tsms_pkg::OSEL_INTERP;
                    cmd.out_last = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> sv/tsms_dp.sv
`include "assert_macros.svh"

module tsms_dp (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             op,
    input  logic [tsms_pkg::PORT_W-1:0]      port,
    input  logic [tsms_pkg::PCT_W-1:0]       percent,
    input  logic [tsms_pkg::TIME_W-1:0]      length_ms,
    input  logic [tsms_pkg::TIME_W-1:0]      wait_ms,
    input  logic [tsms_pkg::TIME_W-1:0]      now_ms,
    input  logic [tsms_pkg::POS_BITS-1:0]    current_position,
    input  logic                             cfg_we,
    input  logic [tsms_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [tsms_pkg::CFG_W-1:0]       cfg_data,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [tsms_pkg::KIND_W-1:0]      kind,
    output logic [tsms_pkg::TIME_W-1:0]      move_id,
    output logic [tsms_pkg::PORT_W-1:0]      out_port,
    output logic [tsms_pkg::POS_BITS-1:0]    position,
    output logic                             last,
    input  tsms_pkg::cmd_t                   cmd,
    output tsms_pkg::sts_t                   sts
);

    localparam int SUM_W = tsms_pkg::FILL_W + 1;

    // configuration
    logic [tsms_pkg::POS_BITS-1:0] min_reg [tsms_pkg::PORTS];
    logic [tsms_pkg::POS_BITS-1:0] max_reg [tsms_pkg::PORTS];

    // captured request
    logic                           op_reg;
    logic [tsms_pkg::PORT_W-1:0]    port_reg;
    logic [tsms_pkg::PCT_W-1:0]     pct_reg;
    logic [tsms_pkg::TIME_W-1:0]    dur_reg;
    logic [tsms_pkg::TIME_W-1:0]    start_reg;
    logic [tsms_pkg::TIME_W-1:0]    now_reg;
    logic [tsms_pkg::POS_BITS-1:0]  src_reg;

    // queue bookkeeping
    logic [tsms_pkg::SLOT_W-1:0]    head_reg [tsms_pkg::PORTS];
    logic [tsms_pkg::FILL_W-1:0]    fill_reg [tsms_pkg::PORTS];
    logic [tsms_pkg::CNT_W-1:0]     cnt_reg;
    logic [tsms_pkg::FILL_W-1:0]    k_reg;

    tsms_pkg::entry_t mem [tsms_pkg::PORTS * tsms_pkg::QUEUE_DEPTH];
    tsms_pkg::entry_t rd_data_reg;

    // target pipeline
    logic signed [tsms_pkg::NUM_W-1:0]  num_reg;
    logic                               neg_t_reg;
    logic [tsms_pkg::MAG_W-1:0]         mag_t_reg;
    logic [tsms_pkg::MULK_W-1:0]        mulk_reg;
    logic [tsms_pkg::POS_BITS-1:0]      tgt_reg;

    // interpolation
    logic [tsms_pkg::PROD_W-1:0]    prod_reg;
    logic                           neg_i_reg;
    logic [tsms_pkg::POS_BITS-1:0]  org_reg;
    logic [tsms_pkg::TIME_W-1:0]    divisor_reg;
    logic [tsms_pkg::TIME_W-1:0]    rem_reg;
    logic [tsms_pkg::PROD_W-1:0]    quo_reg;
    logic [tsms_pkg::DIVC_W-1:0]    div_cnt_reg;

    logic                           pend_vld_reg;
    logic [tsms_pkg::POS_BITS-1:0]  pend_reg;

    logic                           out_valid_reg;
    logic [tsms_pkg::KIND_W-1:0]    kind_reg;
    logic [tsms_pkg::TIME_W-1:0]    id_reg;
    logic [tsms_pkg::PORT_W-1:0]    port_out_reg;
    logic [tsms_pkg::POS_BITS-1:0]  pos_reg;
    logic                           last_reg;

    logic [tsms_pkg::SLOT_W-1:0]    cur_head;
    logic [tsms_pkg::FILL_W-1:0]    cur_fill;
    logic [tsms_pkg::SLOT_W-1:0]    head_inc;
    logic [tsms_pkg::FILL_W-1:0]    k_minus;
    logic [tsms_pkg::ADDR_W-1:0]    port_base;
    logic [tsms_pkg::ADDR_W-1:0]    rd_addr;
    logic [tsms_pkg::ADDR_W-1:0]    wr_addr;
    tsms_pkg::entry_t               wr_data;
    logic                           wr_en;
    logic                           out_free;

    logic [tsms_pkg::POS_BITS-1:0]  eff_origin;
    logic [tsms_pkg::TIME_W-1:0]    elapsed;
    logic signed [tsms_pkg::POS_BITS:0] diff;
    logic [tsms_pkg::POS_BITS-1:0]  diff_mag;

    logic signed [tsms_pkg::NUM_W-1:0] lo_s;
    logic signed [tsms_pkg::NUM_W-1:0] d_s;
    logic signed [tsms_pkg::NUM_W-1:0] pct_s;
    logic signed [tsms_pkg::NUM_W-1:0] num_next;
    logic [tsms_pkg::NUM_W-1:0]        q_est;
    logic [tsms_pkg::NUM_W-1:0]        r_est;
    logic [tsms_pkg::NUM_W-1:0]        q_fix;
    logic [tsms_pkg::POS_BITS-1:0]     tgt_next;

    logic [tsms_pkg::TIME_W:0]      trial;
    logic                           ge;
    logic [tsms_pkg::POS_BITS-1:0]  q_int;
    logic [tsms_pkg::POS_BITS-1:0]  interp_pos;

    function automatic logic [tsms_pkg::SLOT_W-1:0] slot_of(
        input logic [tsms_pkg::SLOT_W-1:0] head,
        input logic [tsms_pkg::FILL_W-1:0] off
    );
        logic [SUM_W-1:0] sum;
        sum = SUM_W'(head) + SUM_W'(off);
        if (sum >= SUM_W'(tsms_pkg::QUEUE_DEPTH))
        begin
            sum = sum - SUM_W'(tsms_pkg::QUEUE_DEPTH);
        end
        return tsms_pkg::SLOT_W'(sum);
    endfunction

    assign cur_head  = head_reg[port_reg];
    assign cur_fill  = fill_reg[port_reg];
    assign head_inc  = (cur_head == tsms_pkg::SLOT_W'(tsms_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : cur_head + 1'b1;
    assign k_minus   = k_reg - 1'b1;
    assign port_base = tsms_pkg::ADDR_W'(port_reg) * tsms_pkg::ADDR_W'(tsms_pkg::QUEUE_DEPTH);
    assign out_free  = !out_valid_reg || !out_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < tsms_pkg::PORTS; p++)
            begin
                min_reg[p] <= '0;
                max_reg[p] <= tsms_pkg::POS_MAX;
            end
        end
        else if (cfg_we && (int'(cfg_index >> 1) < tsms_pkg::PORTS))
        begin
            if (cfg_index[0])
            begin
                max_reg[cfg_index[tsms_pkg::CFG_IDX_W-1:1]] <= tsms_pkg::POS_BITS'(cfg_data);
            end
            else
            begin
                min_reg[cfg_index[tsms_pkg::CFG_IDX_W-1:1]] <= tsms_pkg::POS_BITS'(cfg_data);
            end
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg    <= op;
            port_reg  <= port;
            pct_reg   <= percent;
            dur_reg   <= length_ms;
            start_reg <= now_ms + wait_ms;
            now_reg   <= now_ms;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            src_reg <= current_position;
        end
        else if (cmd.drop)
        begin
            src_reg <= rd_data_reg.target;
        end
    end

    // percent to target: num, reciprocal product, fix-up and saturation
    always_comb
    begin
        lo_s     = $signed(tsms_pkg::NUM_W'(min_reg[port_reg]));
        d_s      = $signed(tsms_pkg::NUM_W'(max_reg[port_reg])) - lo_s;
        pct_s    = $signed(tsms_pkg::NUM_W'(pct_reg));
        num_next = lo_s * $signed(tsms_pkg::NUM_W'(100)) + d_s * pct_s;
        q_est    = tsms_pkg::NUM_W'(mulk_reg >> tsms_pkg::RECIP_SHIFT);
        r_est    = tsms_pkg::NUM_W'(mag_t_reg) - q_est * tsms_pkg::NUM_W'(100);
        q_fix    = (r_est >= tsms_pkg::NUM_W'(100)) ? q_est + 1'b1 : q_est;
        if (neg_t_reg)
        begin
            tgt_next = '0;
        end
        else if (q_fix > tsms_pkg::NUM_W'(tsms_pkg::POS_MAX))
        begin
            tgt_next = tsms_pkg::POS_MAX;
        end
        else
        begin
            tgt_next = tsms_pkg::POS_BITS'(q_fix);
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg   <= num_next;
        neg_t_reg <= num_reg[tsms_pkg::NUM_W-1];
        mag_t_reg <= tsms_pkg::MAG_W'(num_reg);
        mulk_reg  <= tsms_pkg::MULK_W'(tsms_pkg::MAG_W'(num_reg)) *
                     tsms_pkg::MULK_W'(tsms_pkg::RECIP);
        tgt_reg   <= tgt_next;
    end

    // memory ports
    always_comb
    begin
        rd_addr = port_base + tsms_pkg::ADDR_W'(cmd.rd_head ? cur_head : slot_of(cur_head, k_minus));
        wr_en   = cmd.ins_shift || cmd.ins_place || cmd.cap_wb;
        wr_data = rd_data_reg;
        wr_addr = port_base + tsms_pkg::ADDR_W'(slot_of(cur_head, k_reg));
        if (cmd.cap_wb)
        begin
            wr_addr          = port_base + tsms_pkg::ADDR_W'(cur_head);
            wr_data.origin   = eff_origin;
            wr_data.captured = 1'b1;
        end
        else if (cmd.ins_place)
        begin
            wr_data.start    = start_reg;
            wr_data.dur      = dur_reg;
            wr_data.target   = tgt_reg;
            wr_data.origin   = '0;
            wr_data.captured = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_ins || cmd.rd_head)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // queue bookkeeping
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < tsms_pkg::PORTS; p++)
            begin
                head_reg[p] <= '0;
                fill_reg[p] <= '0;
            end
            cnt_reg <= '0;
        end
        else if (cmd.ins_place)
        begin
            fill_reg[port_reg] <= cur_fill + 1'b1;
            cnt_reg            <= cnt_reg + 1'b1;
        end
        else if (cmd.drop)
        begin
            fill_reg[port_reg] <= cur_fill - 1'b1;
            head_reg[port_reg] <= head_inc;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.ins_init)
        begin
            k_reg <= cur_fill;
        end
        else if (cmd.ins_shift)
        begin
            k_reg <= k_minus;
        end
    end

    // head evaluation
    always_comb
    begin
        eff_origin = rd_data_reg.captured ? rd_data_reg.origin : src_reg;
        elapsed    = now_reg - rd_data_reg.start;
        diff       = $signed({1'b0, rd_data_reg.target}) - $signed({1'b0, eff_origin});
        diff_mag   = diff[tsms_pkg::POS_BITS] ? tsms_pkg::POS_BITS'(-diff) :
                                                 tsms_pkg::POS_BITS'(diff);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            prod_reg    <= tsms_pkg::PROD_W'(elapsed) * tsms_pkg::PROD_W'(diff_mag);
            neg_i_reg   <= diff[tsms_pkg::POS_BITS];
            org_reg     <= eff_origin;
            divisor_reg <= rd_data_reg.dur;
        end
    end

    // restoring divider, one quotient bit per cycle
    assign trial = {rem_reg, quo_reg[tsms_pkg::PROD_W-1]};
    assign ge    = (trial >= {1'b0, divisor_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            div_cnt_reg <= '0;
        end
        else if (cmd.div_start)
        begin
            div_cnt_reg <= tsms_pkg::DIVC_W'(tsms_pkg::PROD_W);
        end
        else if (div_cnt_reg != '0)
        begin
            div_cnt_reg <= div_cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= prod_reg;
        end
        else if (div_cnt_reg != '0)
        begin
            rem_reg <= ge ? tsms_pkg::TIME_W'(trial - {1'b0, divisor_reg}) :
                            tsms_pkg::TIME_W'(trial);
            quo_reg <= {quo_reg[tsms_pkg::PROD_W-2:0], ge};
        end
    end

    assign q_int      = tsms_pkg::POS_BITS'(quo_reg);
    assign interp_pos = neg_i_reg ? org_reg - q_int : org_reg + q_int;

    // finished head waiting to learn whether it is the final result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.capture || cmd.pend_clr)
        begin
            pend_vld_reg <= 1'b0;
        end
        else if (cmd.drop)
        begin
            pend_vld_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.drop)
        begin
            pend_reg <= rd_data_reg.target;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            port_out_reg <= port_reg;
            case (cmd.osel)
                tsms_pkg::OSEL_ACCEPT:
                begin
                    kind_reg <= tsms_pkg::KIND_ACCEPT;
                    id_reg   <= {cnt_reg, port_reg};
                    pos_reg  <= tgt_reg;
                    last_reg <= 1'b1;
                end
                tsms_pkg::OSEL_FULL:
                begin
                    kind_reg <= tsms_pkg::KIND_FULL;
                    id_reg   <= '0;
                    pos_reg  <= '0;
                    last_reg <= 1'b1;
                end
                tsms_pkg::OSEL_PEND:
                begin
                    kind_reg <= tsms_pkg::KIND_POSITION;
                    id_reg   <= '0;
                    pos_reg  <= pend_reg;
                    last_reg <= cmd.out_last;
                end
                default:
                begin
                    kind_reg <= tsms_pkg::KIND_POSITION;
                    id_reg   <= '0;
                    pos_reg  <= interp_pos;
                    last_reg <= cmd.out_last;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign move_id   = id_reg;
    assign out_port  = port_out_reg;
    assign position  = pos_reg;
    assign last      = last_reg;

    // status to the controller
    always_comb
    begin
        sts.is_tick     = (op_reg == tsms_pkg::OP_TICK);
        sts.port_ok     = (int'(port_reg) < tsms_pkg::PORTS);
        sts.full        = (cur_fill >= tsms_pkg::FILL_W'(tsms_pkg::QUEUE_DEPTH));
        sts.k_zero      = (k_reg == '0);
        sts.later       = (rd_data_reg.start > start_reg);
        sts.fill_zero   = (cur_fill == '0);
        sts.not_started = (rd_data_reg.start > now_reg);
        sts.finished    = (rd_data_reg.dur == '0) || (elapsed > rd_data_reg.dur);
        sts.div_done    = (div_cnt_reg == '0);
        sts.out_free    = out_free;
        sts.pend_vld    = pend_vld_reg;
    end

    `ASSERT_CLK(a_load_needs_room, cmd.load_out |-> out_free, "result loaded over a stalled result")
    `ASSERT_CLK(a_place_not_full, cmd.ins_place |-> (cur_fill < tsms_pkg::FILL_W'(tsms_pkg::QUEUE_DEPTH)), "insert into a full queue")
    `ASSERT_NEVER(a_drop_empty, cmd.drop && (cur_fill == '0), "head dropped from an empty queue")
    `ASSERT_CLK(a_div_idle, cmd.div_start |-> (div_cnt_reg == '0), "divider restarted while busy")

endmodule

>>> tb/sv/timed_servo_move_scheduler_tb.sv
`timescale 1ns / 1ps

module timed_servo_move_scheduler_tb;
    import tsms_pkg::*;

    // Register map: min and max position for each of the four ports.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_S0_MIN, REG_S0_MAX, REG_S1_MIN, REG_S1_MAX,
        REG_S2_MIN, REG_S2_MAX, REG_S3_MIN, REG_S3_MAX
    } reg_index_t;

    typedef struct {
        logic [TIME_W-1:0]   start;
        logic [TIME_W-1:0]   dur;
        logic [POS_BITS-1:0] target;
        logic [POS_BITS-1:0] origin;
        bit                  captured;
    } move_t;

    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [TIME_W-1:0]   id;
        logic [PORT_W-1:0]   prt;
        logic [POS_BITS-1:0] pos;
        logic                lst;
    } servo_result_t;

    // Hold off before idle-time register writes: a tick that drops a full
    // queue and then interpolates must be done first.
    localparam int SETTLE_CYCLES = 200;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_stall;
    logic                 op = OP_ENQUEUE;
    logic [PORT_W-1:0]    port = '0;
    logic [PCT_W-1:0]     percent = '0;
    logic [TIME_W-1:0]    length_ms = '0;
    logic [TIME_W-1:0]    wait_ms = '0;
    logic [TIME_W-1:0]    now_ms = '0;
    logic [POS_BITS-1:0]  current_position = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [KIND_W-1:0]    kind;
    logic [TIME_W-1:0]    move_id;
    logic [PORT_W-1:0]    out_port;
    logic [POS_BITS-1:0]  position;
    logic                 last;

    // Predictor state: ranges, per-port sorted move queues, id counter.
    logic [POS_BITS-1:0] range_min[PORTS];
    logic [POS_BITS-1:0] range_max[PORTS];
    move_t               moves[PORTS][$];
    logic [CNT_W-1:0]    id_count;

    servo_result_t pending_results[$];
    int                  mismatches;
    int                  stall_left;
    bit                  quiet_mode;
    logic [TIME_W-1:0]   sim_ms;

    timed_servo_move_scheduler i_dut (.*);

    always #1 clk = ~clk;

    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    // Percent to target: floor of (100*min + (max-min)*pct) / 100, clamped.
    function automatic logic [POS_BITS-1:0] target_of(int p, int pct);
        longint num;
        num = longint'(range_min[p]) * 100
            + (longint'(range_max[p]) - longint'(range_min[p])) * pct;
        if (num < 0)
            return '0;
        num = num / 100;
        if (num > longint'(POS_MAX))
            return POS_MAX;
        return num[POS_BITS-1:0];
    endfunction

    // Work out the results of one accepted request and queue them.
    task automatic predict_request();
        servo_result_t r;
        servo_result_t tick_res[$];
        move_t         m;
        logic [TIME_W-1:0]   elapsed;
        logic [POS_BITS-1:0] src;
        longint        diff;
        longint        q;
        int            p;
        int            slot;
        p = port;
        r.id = '0;
        r.prt = port;
        r.lst = 1'b1;
        if (op == OP_ENQUEUE)
        begin
            if (moves[p].size() >= QUEUE_DEPTH)
            begin
                r.kind = KIND_FULL;
                r.pos = '0;
            end
            else
            begin
                m.start = now_ms + wait_ms;
                m.dur = length_ms;
                m.target = target_of(p, percent);
                m.origin = '0;
                m.captured = 0;
                // Insert after every move that starts at the same time or earlier.
                slot = 0;
                while (slot < moves[p].size() && moves[p][slot].start <= m.start)
                    slot++;
                moves[p].insert(slot, m);
                r.kind = KIND_ACCEPT;
                r.id = {id_count, port};
                r.pos = m.target;
                id_count++;
            end
            pending_results.push_back(r);
            return;
        end
        src = current_position;
        r.kind = KIND_POSITION;
        r.lst = 1'b0;
        while (moves[p].size() > 0)
        begin
            if (moves[p][0].start > now_ms)
                break;
            if (!moves[p][0].captured)
            begin
                moves[p][0].origin = src;
                moves[p][0].captured = 1;
            end
            elapsed = now_ms - moves[p][0].start;
            if (moves[p][0].dur == 0 || elapsed > moves[p][0].dur)
            begin
                // Finished head: emit its target, chain it as the next origin.
                r.pos = moves[p][0].target;
                src = r.pos;
                tick_res.push_back(r);
                void'(moves[p].pop_front());
            end
            else
            begin
                diff = longint'(moves[p][0].target) - longint'(moves[p][0].origin);
                q = (longint'(elapsed) * diff) / longint'(moves[p][0].dur);
                r.pos = POS_BITS'(longint'(moves[p][0].origin) + q);
                tick_res.push_back(r);
                break;
            end
        end
        if (tick_res.size() > 0)
            tick_res[$].lst = 1'b1;
        foreach (tick_res[i])
            pending_results.push_back(tick_res[i]);
    endtask

    // Send one request; the random gap goes ahead of it.
    task automatic send_request(logic o, int p, int pct, logic [TIME_W-1:0] dur,
                                logic [TIME_W-1:0] dly, logic [TIME_W-1:0] t,
                                logic [POS_BITS-1:0] cur);
        int gap;
        gap = quiet_mode ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        op = o;
        port = p;
        percent = pct;
        length_ms = dur;
        wait_ms = dly;
        now_ms = t;
        current_position = cur;
        forever
        begin
            @(posedge clk);
            if (!in_stall)
                break;
        end
        predict_request();
        @(negedge clk);
    endtask

    // Drop valid and wait until every expected result has come back.
    task automatic drain();
        in_valid = 1'b0;
        wait (pending_results.size() == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [CFG_W-1:0] val);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = val;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx[0])
            range_max[idx >> 1] = val;
        else
            range_min[idx >> 1] = val;
    endtask

    // Receiver: draw a stall length per result, with quiet stretches.
    always @(negedge clk)
    begin
        if (stall_left > 0)
        begin
            out_stall = 1'b1;
            stall_left--;
        end
        else
            out_stall = 1'b0;
    end

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        servo_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result kind=%0d id=%0h port=%0d pos=%0d last=%0b",
                             kind, move_id, out_port, position, last);
            end
            else
            begin
                e = pending_results.pop_front();
                if (kind !== e.kind || move_id !== e.id || out_port !== e.prt
                    || position !== e.pos || last !== e.lst)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch exp kind=%0d id=%0h port=%0d pos=%0d last=%0b %s",
                                 e.kind, e.id, e.prt, e.pos, e.lst,
                                 $sformatf("got kind=%0d id=%0h port=%0d pos=%0d last=%0b",
                                           kind, move_id, out_port, position, last));
                end
            end
            stall_left = quiet_mode ? 0 : $urandom_range(0, 13);
        end
    end

    // Range extremes, percent saturation, chained drops, tie order and timing.
    task automatic test_directed();
        send_request(OP_ENQUEUE, 0, 0, 0, 0, 0, 11'd5);
        send_request(OP_ENQUEUE, 0, 100, 0, 0, 0, 11'd5);
        send_request(OP_ENQUEUE, 0, 127, 0, 0, 0, 11'd5);
        // Three finished heads in one tick, each chaining its target.
        send_request(OP_TICK, 0, 0, 0, 0, 0, 11'd7);
        // Empty queue: no result.
        send_request(OP_TICK, 0, 0, 0, 0, 100, 11'd7);
        drain();
        // Inverted range on port 1, full-scale range on port 3.
        write_reg(REG_S1_MIN, 11'h7FF);
        write_reg(REG_S1_MAX, 11'h000);
        write_reg(REG_S3_MIN, 11'h000);
        write_reg(REG_S3_MAX, 11'h7FF);
        send_request(OP_ENQUEUE, 1, 127, 1000, 10, 100, 11'h000);
        send_request(OP_ENQUEUE, 1, 50, 1000, 10, 100, 11'h000);
        // Not yet started.
        send_request(OP_TICK, 1, 0, 0, 0, 105, 11'h7FF);
        // Running: downward interpolation from the captured origin.
        send_request(OP_TICK, 1, 0, 0, 0, 333, 11'h7FF);
        // Elapsed equal to duration still interpolates; one past finishes.
        send_request(OP_TICK, 1, 0, 0, 0, 1110, 11'h123);
        send_request(OP_TICK, 1, 0, 0, 0, 1111, 11'h123);
        // Huge duration near the wrap of time: must not end early.
        send_request(OP_ENQUEUE, 3, 100, 32'hFFFF_FFFF, 32'hFFFF_FFF0, 32'h0000_000F,
                     11'h000);
        send_request(OP_TICK, 3, 0, 0, 0, 32'hFFFF_FFFF, 11'h400);
        send_request(OP_TICK, 3, 0, 0, 0, 32'h8000_0000, 11'h400);
        drain();
    endtask

    // Fill one port with equal start times, overflow it, then drop all 16.
    task automatic test_queue_full();
        for (int i = 0; i < QUEUE_DEPTH + 1; i++)
            send_request(OP_ENQUEUE, 2, i * 6, 0, 5, 20, 11'h0);
        send_request(OP_TICK, 2, 0, 0, 0, 25, 11'h155);
        drain();
    endtask

    // Timed move streams with random content plus a share of wild values.
    task automatic test_random_moves(int count);
        logic [TIME_W-1:0] dur;
        logic [TIME_W-1:0] dly;
        logic [TIME_W-1:0] t;
        int p;
        int pct;
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
                quiet_mode = ($urandom_range(0, 3) == 0);
            sim_ms += $urandom_range(0, 60);
            p = $urandom_range(0, PORTS - 1);
            pct = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127)
                                              : $urandom_range(0, 100);
            dur = $urandom_range(0, 300);
            dly = $urandom_range(0, 150);
            t = sim_ms;
            case ($urandom_range(0, 19))
                0: dur = $urandom;
                1: dly = $urandom;
                2: t = $urandom;
                3: dur = 0;
                default: ;
            endcase
            send_request($urandom_range(0, 1) ? OP_TICK : OP_ENQUEUE, p, pct, dur, dly, t,
                         POS_BITS'($urandom));
        end
        // Catch up every queue so later phases start clean.
        quiet_mode = 0;
        for (int q = 0; q < PORTS; q++)
            send_request(OP_TICK, q, 0, 0, 0, 32'hFFFF_FFFF, 11'h0);
        sim_ms = 0;
        for (int q = 0; q < PORTS; q++)
            send_request(OP_TICK, q, 0, 0, 0, 32'h7FFF_FFFF, 11'h0);
    endtask

    // Rewrite every range register with random values or with extreme values.
    task automatic test_reconfig(bit extremes);
        for (int r = 0; r < 2 * PORTS; r++)
            write_reg(reg_index_t'(r), extremes ? (r[0] ? 11'h7FF : 11'h000)
                                                 : CFG_W'($urandom));
    endtask

    initial
    begin
        for (int p = 0; p < PORTS; p++)
        begin
            range_min[p] = '0;
            range_max[p] = POS_MAX;
        end
        id_count = '0;
        mismatches = 0;
        stall_left = 0;
        quiet_mode = 0;
        sim_ms = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        test_directed();
        test_queue_full();
        test_reconfig(0);
        test_random_moves(80);
        drain();
        test_reconfig(0);
        test_random_moves(80);
        drain();
        test_reconfig(1);
        test_random_moves(80);
        drain();
        if (mismatches == 0 && pending_results.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> timed_servo_move_scheduler.f
+incdir+sv
sv/tsms_pkg.sv
sv/tsms_ctrl.sv
sv/tsms_dp.sv
sv/timed_servo_move_scheduler.sv
tb/sv/timed_servo_move_scheduler_tb.sv
